/* design/dnsqm_pkg.sv */
// Shared constants, register indexes and types for the DNS query name matcher.
`timescale 1ns / 1ps
package dnsqm_pkg;

   localparam int MaxPacket      = 512;
   localparam int PosWidth       = $clog2(MaxPacket + 1);
   localparam int NameCapacity   = 64;
   localparam int NameWidth      = 6;
   localparam int DomainCapacity = 32;
   localparam int DomainChars    = 32;
   localparam int DomainIdxWidth = $clog2(DomainChars);
   localparam int DomLenWidth    = 6;
   localparam int HdrLen         = 12;
   localparam int AnswerBytes    = 16;
   localparam int RespWidth      = 10;
   localparam int CsrIndexWidth  = 3;
   localparam int CsrDataWidth   = 64;

   typedef enum logic [CsrIndexWidth-1:0] {
      CsrDomainLow    = 3'd0,
      CsrDomainMid    = 3'd1,
      CsrDomainHigh   = 3'd2,
      CsrDomainTop    = 3'd3,
      CsrDomainLength = 3'd4
   } csr_index_type;

   typedef logic [DomainChars-1:0][7:0] domain_chars_type;

   // verdict formed by the parser for the item just accepted
   typedef struct packed {
      logic                 fire;
      logic                 prefix_ok;
      logic [NameWidth-1:0] name_len;
      logic [RespWidth-1:0] resp_len;
   } verdict_type;

endpackage

/* design/dns_query_name_match_core.sv */
// Top level of the DNS query name matcher: handshake and result register.
//
// Input channel req_*: one DNS payload byte per item, req_last_byte set on
// the final byte of a packet. Bytes 12 onward are parsed as the query name.
// Result channel rsp_*: one item per packet of 12 or more bytes, giving the
// case-insensitive match against the configured domain, the name length and
// the packet length, counted up to 512, plus 16. Shorter packets produce nothing.
// csr_*: write-only registers holding up to 32 domain characters and the
// domain length; write them only between packets.
// Throughput: one byte per cycle while req_ready is high; each byte updates
// the parser state in the cycle it is accepted. Latency: the result is
// valid the cycle after the last byte is accepted.
// The result sits in a single output register; a stall on rsp_ready holds
// it and holds off req_ready only while that register is occupied and not
// being drained. Synchronous reset clears the registers, the parser state
// and the output valid.
`timescale 1ns / 1ps
module dns_query_name_match_core
   import dnsqm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_last_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_matched,
   output logic [NameWidth-1:0]     rsp_name_length,
   output logic [RespWidth-1:0]     rsp_response_length,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wr_data
);

   domain_chars_type       domain_chars;
   logic [DomLenWidth-1:0] domain_len;
   verdict_type            verdict;
   logic                   accept;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   matched_ff;
   logic [NameWidth-1:0]   name_len_ff;
   logic [RespWidth-1:0]   resp_len_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   dnsqm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .domain_chars(domain_chars),
      .domain_len  (domain_len)
   );

   dnsqm_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .last_byte   (req_last_byte),
      .domain_chars(domain_chars),
      .verdict     (verdict)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (verdict.fire)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (verdict.fire) begin
         matched_ff  <= verdict.prefix_ok
                        && (DomLenWidth'(verdict.name_len) == domain_len);
         name_len_ff <= verdict.name_len;
         resp_len_ff <= verdict.resp_len;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_matched         = matched_ff;
   assign rsp_name_length     = name_len_ff;
   assign rsp_response_length = resp_len_ff;

endmodule

/* design/dnsqm_csr.sv */
// Configuration registers: domain characters and effective domain length.
`timescale 1ns / 1ps
module dnsqm_csr
   import dnsqm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wr_data,
   output domain_chars_type         domain_chars,
   output logic [DomLenWidth-1:0]   domain_len
);

   localparam logic [DomLenWidth-1:0] DomLenMax = DomLenWidth'(DomainCapacity);

   logic [3:0][63:0]         chars_ff;
   logic [DomLenWidth-1:0]   len_ff;
   logic [DomLenWidth-1:0]   limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_ff <= '0;
         len_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CsrDomainLow:    chars_ff[0] <= csr_wr_data;
            CsrDomainMid:    chars_ff[1] <= csr_wr_data;
            CsrDomainHigh:   chars_ff[2] <= csr_wr_data;
            CsrDomainTop:    chars_ff[3] <= csr_wr_data;
            CsrDomainLength: len_ff      <= csr_wr_data[DomLenWidth-1:0];
            default: ;
         endcase
      end
   end

   assign domain_chars = chars_ff;
   assign limit        = (len_ff > DomLenMax) ? DomLenMax : len_ff;

   // a zero character cuts the domain short; lowest index wins
   always_comb begin
      domain_len = limit;
      for (int i = DomainChars - 1; i >= 0; i--) begin
         if ((DomLenWidth'(i) < limit) && (domain_chars[i] == 8'h00))
            domain_len = DomLenWidth'(i);
      end
   end

endmodule

/* design/dnsqm_parser.sv */
// Per-byte query name parser with running case-folded compare against the domain.
`timescale 1ns / 1ps
module dnsqm_parser
   import dnsqm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             last_byte,
   input  domain_chars_type domain_chars,
   output verdict_type      verdict
);

   localparam logic [7:0]           DotChar  = 8'h2E;
   localparam logic [NameWidth-1:0] NameFull = NameWidth'(NameCapacity - 1);

   typedef enum logic [1:0] {PhHeader, PhLength, PhLabel, PhDone} phase_type;

   function automatic logic [7:0] fold(input logic [7:0] c);
      fold = (c >= 8'h41 && c <= 8'h5A) ? (c + 8'd32) : c;
   endfunction

   logic [PosWidth-1:0]  pos_ff, pos_in;
   phase_type            phase_ff, phase_in;
   logic [7:0]           remain_ff, remain_in;
   logic [NameWidth-1:0] count_ff, count_in;
   logic [NameWidth-1:0] valid_ff, valid_in;
   logic                 zero_ff, zero_in;
   logic                 match_ff, match_in;
   logic [NameWidth-1:0] cvalid_ff, cvalid_in;
   logic                 cmatch_ff, cmatch_in;

   logic                 app_en;
   logic [7:0]           app_char;
   logic [NameWidth-1:0] cnt_a, valid_a;
   logic                 zero_a, match_a;
   logic                 active, fallback;
   logic [7:0]           dom_char;

   assign active   = pos_ff < PosWidth'(MaxPacket);
   assign dom_char = domain_chars[count_ff[DomainIdxWidth-1:0]];

   always_comb begin
      app_en   = 1'b0;
      app_char = data_byte;
      unique case (phase_ff)
         PhLength: begin
            app_en   = (data_byte != 8'h00) && (pos_ff != PosWidth'(HdrLen));
            app_char = DotChar;
         end
         PhLabel:  app_en = 1'b1;
         PhHeader, PhDone: ;
      endcase

      // append one character, saturating one below the name capacity
      cnt_a   = count_ff;
      valid_a = valid_ff;
      zero_a  = zero_ff;
      match_a = match_ff;
      if (app_en && (count_ff < NameFull)) begin
         cnt_a = count_ff + 1'b1;
         if (!zero_ff) begin
            if (app_char == 8'h00) begin
               zero_a = 1'b1;
            end else begin
               valid_a = valid_ff + 1'b1;
               match_a = match_ff && (fold(app_char) == fold(dom_char));
            end
         end
      end

      pos_in    = pos_ff;
      phase_in  = phase_ff;
      remain_in = remain_ff;
      count_in  = count_ff;
      valid_in  = valid_ff;
      zero_in   = zero_ff;
      match_in  = match_ff;
      cvalid_in = cvalid_ff;
      cmatch_in = cmatch_ff;
      if (accept && active) begin
         pos_in   = pos_ff + 1'b1;
         count_in = cnt_a;
         valid_in = valid_a;
         zero_in  = zero_a;
         match_in = match_a;
         unique case (phase_ff)
            PhHeader: begin
               if (pos_ff == PosWidth'(HdrLen - 1))
                  phase_in = PhLength;
            end
            PhLength: begin
               if (data_byte == 8'h00) begin
                  phase_in = PhDone;
               end else if (cnt_a >= NameFull) begin
                  phase_in = PhDone;
               end else begin
                  cvalid_in = valid_a;
                  cmatch_in = match_a;
                  remain_in = data_byte;
                  phase_in  = PhLabel;
               end
            end
            PhLabel: begin
               remain_in = remain_ff - 8'd1;
               if (remain_in == 8'd0)
                  phase_in = PhLength;
            end
            PhDone: ;
         endcase
      end

      // packet ending inside a label drops that label
      fallback           = (phase_in == PhLabel) && (remain_in != 8'd0);
      verdict.fire       = accept && last_byte && (pos_in >= PosWidth'(HdrLen));
      verdict.name_len   = fallback ? cvalid_in : valid_in;
      verdict.prefix_ok  = fallback ? cmatch_in : match_in;
      verdict.resp_len   = RespWidth'(pos_in + PosWidth'(AnswerBytes));
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         pos_ff    <= '0;
         phase_ff  <= PhHeader;
         remain_ff <= '0;
         count_ff  <= '0;
         valid_ff  <= '0;
         zero_ff   <= 1'b0;
         match_ff  <= 1'b1;
         cvalid_ff <= '0;
         cmatch_ff <= 1'b1;
      end else begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
         count_ff  <= count_in;
         valid_ff  <= valid_in;
         zero_ff   <= zero_in;
         match_ff  <= match_in;
         cvalid_ff <= cvalid_in;
         cmatch_ff <= cmatch_in;
      end
   end

endmodule

/* design/dnsqm_checker.sv */
// Port-level checks for the DNS query name matcher, bound to the top level.
`timescale 1ns / 1ps
module dnsqm_checker
   import dnsqm_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_matched,
   input logic [NameWidth-1:0] rsp_name_length,
   input logic [RespWidth-1:0] rsp_response_length
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_matched)
         && $stable(rsp_name_length) && $stable(rsp_response_length))
      else $error("stalled result item changed");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input stalled with room in result register");

   a_resp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_response_length >= RespWidth'(HdrLen + AnswerBytes)
         && rsp_response_length <= RespWidth'(MaxPacket + AnswerBytes))
      else $error("response length out of range");

   a_match_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_matched |-> rsp_name_length <= NameWidth'(DomainCapacity))
      else $error("match reported with name longer than domain");

endmodule

bind dns_query_name_match_core dnsqm_checker u_dnsqm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_matched        (rsp_matched),
   .rsp_name_length    (rsp_name_length),
   .rsp_response_length(rsp_response_length)
);

/* tb/dns_query_name_match_core_test.sv */
// Self-checking testbench for the DNS query name matcher core.
`timescale 1ns / 1ps

import dnsqm_pkg::*;

typedef enum logic [1:0] {StHeader, StLength, StLabel, StDone} name_stage_type;

typedef struct packed {
   logic                 matched;
   logic [NameWidth-1:0] name_len;
   logic [RespWidth-1:0] resp_len;
} expected_verdict_type;

function automatic byte unsigned fold_case(byte unsigned c);
   return (c >= 8'h41 && c <= 8'h5A) ? 8'(c + 8'd32) : c;
endfunction

// Tracks the query name of the packet in flight and queues the verdicts it must yield.
class verdict_board;
   logic [63:0]          dom_regs[4];
   logic [5:0]           dom_len;
   int                   offset;
   name_stage_type       stage;
   int                   label_left;
   int                   name_fill;
   int                   fallback_fill;
   byte unsigned         name_chars[NameCapacity];
   expected_verdict_type pending_verdicts[$];
   int                   errors;
   int                   checked;
   int                   match_count;
   int                   bytes_taken;

   function new();
      foreach (dom_regs[i]) dom_regs[i] = '0;
      dom_len = '0;
      errors = 0;
      checked = 0;
      match_count = 0;
      bytes_taken = 0;
      clear_packet();
   endfunction

   function void set_reg(csr_index_type idx, logic [63:0] val);
      case (idx)
         CsrDomainLow:    dom_regs[0] = val;
         CsrDomainMid:    dom_regs[1] = val;
         CsrDomainHigh:   dom_regs[2] = val;
         CsrDomainTop:    dom_regs[3] = val;
         CsrDomainLength: dom_len = val[5:0];
         default: ;
      endcase
   endfunction

   function void clear_packet();
      offset = 0;
      stage = StHeader;
      label_left = 0;
      name_fill = 0;
      fallback_fill = 0;
      foreach (name_chars[i]) name_chars[i] = 0;
   endfunction

   function void push_char(byte unsigned c);
      if (name_fill < NameCapacity - 1) begin
         name_chars[name_fill] = c;
         name_fill++;
      end
   endfunction

   function byte unsigned dom_char(int i);
      return dom_regs[i / 8][(i % 8) * 8 +: 8];
   endfunction

   function void advance(byte unsigned b);
      case (stage)
         StHeader: if (offset == HdrLen - 1) stage = StLength;
         StLength: begin
            if (b == 0) begin
               stage = StDone;
            end else begin
               if (offset != HdrLen) push_char(8'h2E);
               if (name_fill >= NameCapacity - 1) begin
                  stage = StDone;
               end else begin
                  fallback_fill = name_fill;
                  label_left = b;
                  stage = StLabel;
               end
            end
         end
         StLabel: begin
            push_char(b);
            label_left = (label_left - 1) & 255;
            if (label_left == 0) stage = StLength;
         end
         default: ;
      endcase
   endfunction

   function void take_byte(byte unsigned b, bit last);
      expected_verdict_type v;
      int nlen;
      int dlen;
      bit same;
      bytes_taken++;
      if (offset < MaxPacket) begin
         advance(b);
         offset++;
      end
      if (!last) return;
      if (offset < HdrLen) begin
         clear_packet();
         return;
      end
      // packet ended inside a label: drop that label
      if (stage == StLabel && label_left != 0) name_fill = fallback_fill;
      nlen = 0;
      while (nlen < name_fill && name_chars[nlen] != 0) nlen++;
      dlen = (dom_len > DomainCapacity) ? DomainCapacity : int'(dom_len);
      for (int i = 0; i < dlen; i++) begin
         if (dom_char(i) == 0) begin
            dlen = i;
            break;
         end
      end
      same = (nlen == dlen);
      for (int i = 0; same && i < nlen; i++)
         if (fold_case(name_chars[i]) != fold_case(dom_char(i))) same = 0;
      v.matched = same;
      v.name_len = NameWidth'(nlen);
      v.resp_len = RespWidth'(offset + AnswerBytes);
      pending_verdicts.push_back(v);
      clear_packet();
   endfunction

   function void check_verdict(logic m, logic [NameWidth-1:0] nl, logic [RespWidth-1:0] rl);
      expected_verdict_type want;
      if (pending_verdicts.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("ERROR: unexpected verdict matched=%0d name_length=%0d response_length=%0d",
                     m, nl, rl);
         return;
      end
      want = pending_verdicts.pop_front();
      checked++;
      if (want.matched) match_count++;
      if (m !== want.matched || nl !== want.name_len || rl !== want.resp_len) begin
         errors++;
         if (errors <= 10)
            $display("ERROR: verdict %0d: expected matched=%0d name_length=%0d %s%0d, %s%0d/%0d/%0d",
                     checked, want.matched, want.name_len, "response_length=", want.resp_len,
                     "got ", m, nl, rl);
      end
   endfunction
endclass

module dns_query_name_match_core_test;

   localparam int CycleLimit = 400000;
   localparam int PhaseBytes = 100;

   typedef byte unsigned byte_q_type[$];

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_data_byte = '0;
   logic                     req_last_byte = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_matched;
   logic [NameWidth-1:0]     rsp_name_length;
   logic [RespWidth-1:0]     rsp_response_length;
   logic                     csr_wr_en = 1'b0;
   csr_index_type            csr_index = CsrDomainLow;
   logic [CsrDataWidth-1:0]  csr_wr_data = '0;

   verdict_board board = new();
   string        alphabet = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_@[`{";
   byte_q_type   pkt;
   byte_q_type   dom_text;
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   int           hold_left = 0;
   int           packets = 0;
   int           short_packets = 0;
   int           long_packets = 0;
   int           domain_setups = 0;

   dns_query_name_match_core dut (.*);

   always #6 clock = ~clock;

   initial begin : receiver
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_verdict(rsp_matched, rsp_name_length, rsp_response_length);
   end

   initial begin : watchdog
      repeat (CycleLimit) @(posedge clock);
      $display("dns_query_name_match_core_test: done, errors");
      $finish;
   end

   function automatic byte unsigned rand_char();
      return alphabet[$urandom_range(alphabet.len() - 1)];
   endfunction

   // n characters of dot-separated labels, no empty label
   function automatic byte_q_type make_dotted(int n);
      byte_q_type s;
      for (int i = 0; i < n; i++) begin
         if (i > 0 && i < n - 1 && s[i-1] != 8'h2E && $urandom_range(4) == 0)
            s.push_back(8'h2E);
         else
            s.push_back(rand_char());
      end
      return s;
   endfunction

   function automatic byte_q_type recase(byte_q_type t);
      foreach (t[i])
         if (fold_case(t[i]) >= 8'h61 && fold_case(t[i]) <= 8'h7A && $urandom_range(1))
            t[i] = t[i] ^ 8'h20;
      return t;
   endfunction

   function automatic byte_q_type near_miss();
      byte_q_type t;
      int p;
      byte unsigned c;
      t = dom_text;
      case ($urandom_range(3))
         0: if (t.size() > 0) begin
            p = $urandom_range(t.size() - 1);
            if (t[p] != 8'h2E) begin
               c = rand_char();
               while (fold_case(c) == fold_case(t[p])) c = rand_char();
               t[p] = c;
            end
         end
         1: if (t.size() > 0) void'(t.pop_back());
         2: t.push_back(rand_char());
         default: t = make_dotted($urandom_range(1, 40));
      endcase
      return t;
   endfunction

   function automatic void add_header();
      repeat (HdrLen) pkt.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void add_name(byte_q_type text);
      int start;
      start = 0;
      for (int i = 0; i <= text.size(); i++) begin
         if (i == text.size() || text[i] == 8'h2E) begin
            pkt.push_back(8'(i - start));
            for (int j = start; j < i; j++) pkt.push_back(text[j]);
            start = i + 1;
         end
      end
   endfunction

   function automatic void build_packet();
      int k;
      int len;
      int p;
      byte_q_type t;
      k = $urandom_range(99);
      pkt.delete();
      if (k < 12) begin
         repeat ($urandom_range(1, HdrLen - 1)) pkt.push_back(8'($urandom_range(255)));
         return;
      end
      add_header();
      if (k < 14) begin
         // header only
      end else if (k < 80) begin
         t = $urandom_range(1) ? recase(dom_text) : near_miss();
         add_name(t);
         pkt.push_back(8'h00);
         repeat ($urandom_range(0, 6)) pkt.push_back(8'($urandom_range(255)));
         if (k >= 66) begin
            len = $urandom_range(HdrLen, pkt.size());
            while (pkt.size() > len) void'(pkt.pop_back());
         end
      end else if (k < 88) begin
         // long labels that can overflow the name buffer
         case ($urandom_range(3))
            0: len = 60;
            1: len = 62;
            2: len = 63;
            default: len = $urandom_range(20, 63);
         endcase
         pkt.push_back(8'(len));
         repeat (len) pkt.push_back(rand_char());
         repeat ($urandom_range(1, 2)) begin
            len = $urandom_range(1, 10);
            pkt.push_back(8'(len));
            repeat (len) pkt.push_back(rand_char());
         end
         pkt.push_back(8'h00);
      end else if (k < 94) begin
         // zero character inside a label
         t = make_dotted($urandom_range(2, 30));
         p = $urandom_range(t.size() - 1);
         if (t[p] != 8'h2E) t[p] = 8'h00;
         add_name(t);
         pkt.push_back(8'h00);
      end else begin
         repeat ($urandom_range(1, 40)) begin
            case ($urandom_range(7))
               0, 1: pkt.push_back(8'($urandom_range(1, 4)));
               2: pkt.push_back($urandom_range(1) ? 8'hC0 : 8'h80);
               3: pkt.push_back(8'h3C);
               default: pkt.push_back(8'($urandom_range(255)));
            endcase
         end
      end
   endfunction

   task automatic send_byte(byte unsigned b, bit last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data_byte = b;
      req_last_byte = last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.take_byte(b, last);
   endtask

   task automatic send_packet();
      packets++;
      if (pkt.size() < HdrLen) short_packets++;
      if (pkt.size() > MaxPacket) long_packets++;
      foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CsrDataWidth-1:0] val);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wr_data = val;
      board.set_reg(idx, val);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // chars visible characters; a longer length register sees a zero terminator
   task automatic set_domain(int chars, int len_reg);
      byte_q_type t;
      logic [63:0] regs[4];
      byte unsigned c;
      t = make_dotted(chars);
      dom_text = t;
      for (int i = 0; i < DomainChars; i++) begin
         if (i < chars) c = t[i];
         else if (i == chars && len_reg > chars) c = 8'h00;
         else c = 8'($urandom_range(255));
         regs[i / 8][(i % 8) * 8 +: 8] = c;
      end
      csr_write(CsrDomainLow, regs[0]);
      csr_write(CsrDomainMid, regs[1]);
      csr_write(CsrDomainHigh, regs[2]);
      csr_write(CsrDomainTop, regs[3]);
      csr_write(CsrDomainLength, CsrDataWidth'(len_reg));
      domain_setups++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      int start;
      int chars;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      set_domain(0, 0);
      pkt = '{8'hFF};
      send_packet();
      pkt.delete();
      for (int i = 0; i < HdrLen; i++) pkt.push_back(i[0] ? 8'hFF : 8'h00);
      send_packet();
      pkt.delete();
      repeat (HdrLen) pkt.push_back(8'h00);
      pkt.push_back(8'h00);
      send_packet();
      settle();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_domain(0, 0);
            1: set_domain(32, 32);
            2: set_domain(32, 63);
            3: begin
               chars = $urandom_range(1, 20);
               set_domain(chars, $urandom_range(chars + 1, 32));
            end
            default: begin
               chars = $urandom_range(1, 31);
               set_domain(chars, chars);
            end
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 73; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 73; end
            default: begin send_idle_pct = 16; stall_pct = 16; end
         endcase
         if (ph == 4) hold_left = 250;
         if (ph == 6) begin
            pkt.delete();
            add_header();
            add_name(recase(dom_text));
            pkt.push_back(8'h00);
            chars = $urandom_range(MaxPacket + 1, MaxPacket + 18);
            while (pkt.size() < chars) pkt.push_back(8'($urandom_range(255)));
            send_packet();
         end
         start = board.bytes_taken;
         while (board.bytes_taken - start < PhaseBytes) begin
            build_packet();
            send_packet();
         end
         settle();
      end

      $display("covered %0d packets (%0d below header size, %0d over %0d bytes), %0d bytes, %s",
               packets, short_packets, long_packets, MaxPacket, board.bytes_taken,
               $sformatf("%0d verdicts, %0d matching", board.checked, board.match_count));
      $display("%0d domain setups incl. empty, full, saturated and zero-terminated; %s",
               domain_setups, "mixed idle/stall on both sides plus one long receiver hold");
      if (board.errors == 0 && board.pending_verdicts.size() == 0)
         $display("dns_query_name_match_core_test: done, clean");
      else
         $display("dns_query_name_match_core_test: done, errors");
      $finish;
   end

endmodule
